[hdl/npst_pkg.sv]
// Shared types and constants for the nearest position tracker.
// Holds the CORDIC arctangent table, angle constants and controller commands.
// No dependencies.
package npst_pkg;

	localparam int unsigned MaxSteps = 24;
	localparam logic signed [25:0] Deg90 = 26'sd5898240;
	localparam logic signed [25:0] Deg180 = 26'sd11796480;
	localparam logic signed [25:0] Deg360 = 26'sd23592960;
	localparam logic signed [33:0] CordicK = 34'sd652032874;
	localparam logic [43:0] DistMax = 44'hFFFFFFFFFFF;
	localparam logic signed [24:0] RefRadius = 25'sd1630976;

	localparam logic [0:0] RegLat = 1'b0;
	localparam logic [0:0] RegLon = 1'b1;

	// Operation selected for the shared multiplier.
	typedef enum logic [2:0] {
		MUL_RCLAT = 3'd0,
		MUL_X = 3'd1,
		MUL_Y = 3'd2,
		MUL_Z = 3'd3,
		MUL_DX = 3'd4,
		MUL_DY = 3'd5,
		MUL_DZ = 3'd6
	} mul_op_t;

	typedef struct packed {
		logic load_item;     // capture report fields, start latitude CORDIC
		logic load_ref;      // start reference conversion
		logic cordic_start;  // load CORDIC with current angle
		logic cordic_step;   // one rotation step
		logic cordic_lat;    // store CORDIC result as latitude terms
		logic cordic_lon;    // store CORDIC result as longitude terms
		logic mul_en;        // perform a multiply step
		mul_op_t mul_op;
		logic store_ref;     // copy xyz to reference
		logic finish;        // update minimum and load output
	} npst_cmd_t;

	typedef struct packed {
		logic cordic_done;
	} npst_stat_t;

	function automatic logic signed [22:0] atan_deg(input logic [4:0] i);
		case (i)
			5'd0: atan_deg = 23'sd2949120;
			5'd1: atan_deg = 23'sd1740967;
			5'd2: atan_deg = 23'sd919879;
			5'd3: atan_deg = 23'sd466945;
			5'd4: atan_deg = 23'sd234379;
			5'd5: atan_deg = 23'sd117304;
			5'd6: atan_deg = 23'sd58666;
			5'd7: atan_deg = 23'sd29335;
			5'd8: atan_deg = 23'sd14668;
			5'd9: atan_deg = 23'sd7334;
			5'd10: atan_deg = 23'sd3667;
			5'd11: atan_deg = 23'sd1833;
			5'd12: atan_deg = 23'sd917;
			5'd13: atan_deg = 23'sd458;
			5'd14: atan_deg = 23'sd229;
			5'd15: atan_deg = 23'sd115;
			5'd16: atan_deg = 23'sd57;
			5'd17: atan_deg = 23'sd29;
			5'd18: atan_deg = 23'sd14;
			5'd19: atan_deg = 23'sd7;
			5'd20: atan_deg = 23'sd4;
			5'd21: atan_deg = 23'sd2;
			5'd22: atan_deg = 23'sd1;
			default: atan_deg = 23'sd0;
		endcase
	endfunction

endpackage

[hdl/npst_ctrl.sv]
// Controller state machine for the nearest position tracker.
// Sequences reference updates and report processing. Depends on npst_pkg.
module npst_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic cfg_fire,
	input logic out_busy,
	input npst_pkg::npst_stat_t stat,
	output logic in_ready,
	output logic cfg_ready,
	output npst_pkg::npst_cmd_t cmd
);
	import npst_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_LAT_RUN = 12'b000000000010,
		S_LON_START = 12'b000000000100,
		S_LON_RUN = 12'b000000001000,
		S_M_RC = 12'b000000010000,
		S_M_X = 12'b000000100000,
		S_M_Y = 12'b000001000000,
		S_M_Z = 12'b000010000000,
		S_M_DX = 12'b000100000000,
		S_M_DY = 12'b001000000000,
		S_M_DZ = 12'b010000000000,
		S_FIN = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic is_ref_q;
	logic boot_q;

	// The reference is recomputed after every register write; it must finish
	// before the next item, which the idle rule for configuration ensures.
	// Right after reset one reference pass runs for the reset register values.
	assign cfg_ready = (state_q == S_IDLE) && !boot_q;
	assign in_ready = (state_q == S_IDLE) && !boot_q && !cfg_fire;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_op = MUL_RCLAT;
		case (state_q)
			S_IDLE: begin
				if (cfg_fire || boot_q) begin
					cmd.load_ref = 1'b1;
					cmd.cordic_start = 1'b1;
					state_d = S_LAT_RUN;
				end else if (in_fire) begin
					cmd.load_item = 1'b1;
					cmd.cordic_start = 1'b1;
					state_d = S_LAT_RUN;
				end
			end
			S_LAT_RUN: begin
				cmd.cordic_step = 1'b1;
				if (stat.cordic_done) begin
					cmd.cordic_step = 1'b0;
					cmd.cordic_lat = 1'b1;
					state_d = S_LON_START;
				end
			end
			S_LON_START: begin
				cmd.cordic_start = 1'b1;
				state_d = S_LON_RUN;
			end
			S_LON_RUN: begin
				cmd.cordic_step = 1'b1;
				if (stat.cordic_done) begin
					cmd.cordic_step = 1'b0;
					cmd.cordic_lon = 1'b1;
					state_d = S_M_RC;
				end
			end
			S_M_RC: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_RCLAT;
				state_d = S_M_X;
			end
			S_M_X: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_X;
				state_d = S_M_Y;
			end
			S_M_Y: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_Y;
				state_d = S_M_Z;
			end
			S_M_Z: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_Z;
				state_d = is_ref_q ? S_FIN : S_M_DX;
			end
			S_M_DX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_DX;
				state_d = S_M_DY;
			end
			S_M_DY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_DY;
				state_d = S_M_DZ;
			end
			S_M_DZ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_DZ;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (is_ref_q) begin
					cmd.store_ref = 1'b1;
					state_d = S_IDLE;
				end else if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			is_ref_q <= 1'b0;
			boot_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cmd.load_ref) is_ref_q <= 1'b1;
			else if (cmd.load_item) is_ref_q <= 1'b0;
			if (cmd.load_ref) boot_q <= 1'b0;
		end
	end

endmodule

[hdl/npst_datapath.sv]
// Datapath of the nearest position tracker: CORDIC unit, shared multiplier,
// distance accumulator, running minimum and output register. Uses npst_pkg.
module npst_datapath #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input npst_pkg::npst_cmd_t cmd,
	output npst_pkg::npst_stat_t stat,
	input logic [23:0] cfg_lat,
	input logic [24:0] cfg_lon,
	input logic [169:0] in_word,
	output logic [192:0] out_word,
	output logic out_valid,
	input logic out_ready
);
	import npst_pkg::*;

	localparam int unsigned Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
	localparam logic [4:0] LastStep = 5'(Steps - 1);

	logic first_q;
	logic [23:0] icao_q;
	logic [63:0] call_q;
	logic [15:0] country_q;
	logic signed [24:0] lon_q;
	logic signed [24:0] r_q;

	logic signed [35:0] cx_q, cy_q;
	logic signed [25:0] cz_q;
	logic [4:0] step_q;
	logic neg_q;
	logic signed [35:0] clat_q, slat_q, clon_q, slon_q;

	logic signed [35:0] rc_q;
	logic signed [24:0] px_q, py_q, pz_q;
	logic signed [24:0] refx_q, refy_q, refz_q;
	logic [46:0] acc_q;

	logic [43:0] min_q;
	logic [23:0] bicao_q;
	logic [63:0] bcall_q;
	logic [15:0] bcountry_q;

	// Angle wrap and fold before the rotation.
	logic signed [25:0] ang_w, ang_f;
	logic fold_neg;
	always_comb begin
		ang_w = (cmd.load_item || cmd.load_ref) ?
			(cmd.load_ref ? 26'(signed'(cfg_lat)) : 26'(signed'(in_word[128:105])))
			: 26'(lon_q);
		if (ang_w >= Deg180) ang_w = ang_w - Deg360;
		if (ang_w < -Deg180) ang_w = ang_w + Deg360;
		fold_neg = 1'b0;
		ang_f = ang_w;
		if (ang_w > Deg90) begin
			ang_f = ang_w - Deg180;
			fold_neg = 1'b1;
		end else if (ang_w < -Deg90) begin
			ang_f = ang_w + Deg180;
			fold_neg = 1'b1;
		end
	end

	assign stat.cordic_done = (step_q == 5'(Steps));

	// Altitude to radius: floor(((6371000 + alt) * 256 + 500) / 1000) by
	// reciprocal multiply with a correction step.
	logic signed [15:0] alt;
	logic [31:0] num;
	logic [57:0] qprod;
	logic [24:0] qest;
	logic [34:0] qrem;
	logic [24:0] rad;
	always_comb begin
		alt = signed'(in_word[169:154]);
		num = 32'((33'sd6371000 + 33'(alt)) * 33'sd256 + 33'sd500);
		qprod = 58'(num) * 58'd4294967;
		qest = qprod[56:32];
		qrem = 35'(num) - 35'(qest) * 35'd1000;
		rad = (qrem >= 35'd1000) ? qest + 25'd1 : qest;
	end

	// Shared multiplier.
	logic signed [35:0] ma, mb;
	logic signed [71:0] mp;
	logic signed [41:0] mq;
	logic signed [25:0] dd;
	always_comb begin
		ma = 36'(r_q);
		mb = clat_q;
		dd = 26'(px_q) - 26'(refx_q);
		case (cmd.mul_op)
			MUL_RCLAT: begin ma = 36'(r_q); mb = clat_q; end
			MUL_X: begin ma = rc_q; mb = clon_q; end
			MUL_Y: begin ma = rc_q; mb = slon_q; end
			MUL_Z: begin ma = 36'(r_q); mb = slat_q; end
			MUL_DX: dd = 26'(px_q) - 26'(refx_q);
			MUL_DY: dd = 26'(py_q) - 26'(refy_q);
			MUL_DZ: dd = 26'(pz_q) - 26'(refz_q);
			default: ;
		endcase
		if (cmd.mul_op == MUL_DX || cmd.mul_op == MUL_DY || cmd.mul_op == MUL_DZ) begin
			ma = 36'(dd);
			mb = 36'(dd);
		end
		mp = 72'(ma) * 72'(mb);
		mq = 42'((mp + 72'sd536870912) >>> 30);
	end

	logic [47:0] acc_sum;
	logic [43:0] dist_sat;
	logic better;
	always_comb begin
		acc_sum = 48'(acc_q) + 48'(mp[51:0]);
		dist_sat = (acc_q > 47'(DistMax)) ? DistMax : acc_q[43:0];
		better = dist_sat < (first_q ? DistMax : min_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			first_q <= in_word[0];
			icao_q <= in_word[24:1];
			call_q <= in_word[88:25];
			country_q <= in_word[104:89];
			lon_q <= signed'(in_word[153:129]);
			r_q <= 25'(rad);
		end
		if (cmd.load_ref) begin
			lon_q <= signed'(cfg_lon);
			r_q <= RefRadius;
		end
		if (cmd.cordic_start) begin
			cx_q <= 36'(CordicK);
			cy_q <= '0;
			cz_q <= ang_f;
			neg_q <= fold_neg;
			step_q <= '0;
		end else if (cmd.cordic_step && step_q <= LastStep) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - (cy_q >>> step_q);
				cy_q <= cy_q + (cx_q >>> step_q);
				cz_q <= cz_q - 26'(atan_deg(step_q));
			end else begin
				cx_q <= cx_q + (cy_q >>> step_q);
				cy_q <= cy_q - (cx_q >>> step_q);
				cz_q <= cz_q + 26'(atan_deg(step_q));
			end
			step_q <= step_q + 5'd1;
		end
		if (cmd.cordic_lat) begin
			clat_q <= neg_q ? -cx_q : cx_q;
			slat_q <= neg_q ? -cy_q : cy_q;
		end
		if (cmd.cordic_lon) begin
			clon_q <= neg_q ? -cx_q : cx_q;
			slon_q <= neg_q ? -cy_q : cy_q;
			acc_q <= '0;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_op)
				MUL_RCLAT: rc_q <= 36'(mq);
				MUL_X: px_q <= 25'(mq);
				MUL_Y: py_q <= 25'(mq);
				MUL_Z: pz_q <= 25'(mq);
				default: acc_q <= acc_sum[47] ? 47'h7FFFFFFFFFFF : acc_sum[46:0];
			endcase
		end
		if (cmd.store_ref) begin
			refx_q <= px_q;
			refy_q <= py_q;
			refz_q <= pz_q;
		end
	end

	// Running minimum and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= DistMax;
			bicao_q <= '0;
			bcall_q <= '0;
			bcountry_q <= '0;
			out_valid <= 1'b0;
			out_word <= '0;
		end else begin
			if (cmd.finish) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.finish) begin
				out_word[43:0] <= dist_sat;
				out_word[44] <= better;
				if (better) begin
					min_q <= dist_sat;
					bicao_q <= icao_q;
					bcall_q <= call_q;
					bcountry_q <= country_q;
					out_word[88:45] <= dist_sat;
					out_word[112:89] <= icao_q;
					out_word[176:113] <= call_q;
					out_word[192:177] <= country_q;
				end else if (first_q) begin
					min_q <= DistMax;
					bicao_q <= '0;
					bcall_q <= '0;
					bcountry_q <= '0;
					out_word[88:45] <= DistMax;
					out_word[192:89] <= '0;
				end else begin
					out_word[88:45] <= min_q;
					out_word[112:89] <= bicao_q;
					out_word[176:113] <= bcall_q;
					out_word[192:177] <= bcountry_q;
				end
			end
		end
	end

endmodule

[hdl/nearest_position_on_sphere_tracker.sv]
// Top level of the nearest position tracker.
// Instantiates npst_ctrl and npst_datapath; uses npst_pkg.
//
// Usage: position reports enter on the s_axis channel, one word per report.
// Each report is converted to Cartesian coordinates on a 6371 km sphere and
// its squared distance to the configured reference is compared with the
// running minimum; one result word leaves on m_axis for every report.
// The cfg channel writes register 0 (reference latitude) or 1 (reference
// longitude); each write recomputes the reference point, during which no
// report is accepted.
// A report is worked through in two CORDIC passes of the single shared
// rotation unit and seven passes through the shared multiplier. One report
// is in work at a time, and the next one can be accepted the cycle after
// the result is loaded.
// After reset the minimum is all ones, the identifiers are zero and the block
// first computes the reference point at latitude 0, longitude 0, with both
// ready outputs low.
// A finished result waits in the output register; if the receiver stalls,
// the next report is still accepted and computed, and it waits at its last
// step until the output register is free.
module nearest_position_on_sphere_tracker #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: icao_address, call_sign, country_tag, latitude,
	// longitude, altitude_m, zero pad.
	input logic [175:0] s_axis_tdata,
	input logic s_axis_tuser,  // first_of_scan
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// Fields from bit 0: item_distance_sq, updated, best_distance_sq, best_icao,
	// best_call_sign, country tag of the closest report, zero pad.
	output logic [199:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [24:0] cfg_data
);
	import npst_pkg::*;

	npst_cmd_t cmd;
	npst_stat_t stat;
	logic in_fire, cfg_fire;
	logic [23:0] ref_lat_q;
	logic [24:0] ref_lon_q;
	logic [192:0] out_word;
	logic [169:0] in_word;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_fire = cfg_valid && cfg_ready;
	// Internal order: first_of_scan at bit 0, then the tdata fields.
	assign in_word = {s_axis_tdata[168:0], s_axis_tuser};

	// The register file; the datapath reads the written value directly so the
	// recomputation can start in the same cycle.
	logic [23:0] lat_next;
	logic [24:0] lon_next;
	always_comb begin
		lat_next = ref_lat_q;
		lon_next = ref_lon_q;
		if (cfg_fire) begin
			case (cfg_index)
				RegLat: lat_next = cfg_data[23:0];
				RegLon: lon_next = cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
		end else begin
			ref_lat_q <= lat_next;
			ref_lon_q <= lon_next;
		end
	end

	npst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.cfg_fire(cfg_fire),
		.out_busy(m_axis_tvalid && !m_axis_tready),
		.stat(stat),
		.in_ready(s_axis_tready),
		.cfg_ready(cfg_ready),
		.cmd(cmd)
	);

	npst_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_lat(lat_next),
		.cfg_lon(lon_next),
		.in_word(in_word),
		.out_word(out_word),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {7'd0, out_word};

endmodule

[tb/nearest_position_on_sphere_tracker_tb.sv]
// Self-checking testbench for nearest_position_on_sphere_tracker.
// Predicts each result word with a CORDIC position model and a running minimum
// tracker kept in a small scoreboard class; depends on npst_pkg and the RTL.
module nearest_position_on_sphere_tracker_tb;
	import npst_pkg::*;

	localparam int unsigned Steps = 16;
	localparam longint Mask44 = 64'hFFFFFFFFFFF;

	// Receiver pacing knob.
	localparam int unsigned HoldCycles = 300;

	typedef struct {
		bit first;
		bit [23:0] icao;
		bit [63:0] call;
		bit [15:0] country;
		int lat;
		int lon;
		int alt;
	} report_t;

	typedef struct {
		bit [43:0] item_sq;
		bit upd;
		bit [43:0] best;
		bit [23:0] icao;
		bit [63:0] call;
		bit [15:0] country;
	} nearest_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [175:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [199:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = RegLat;
	logic [24:0] cfg_data = '0;

	int errors = 0;
	bit hold_rx = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	nearest_position_on_sphere_tracker #(.CORDIC_STEPS(Steps)) DUT (.*);

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Arithmetic right shift on a 64-bit signed value.
	function automatic longint shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// CORDIC sine and cosine of an angle in degrees times 65536, result in Q30.
	function automatic void cordic_sincos(input longint ang, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		bit neg;
		x = CordicK;
		y = 0;
		neg = 1'b0;
		if (ang >= Deg180) ang -= Deg360;
		if (ang < -Deg180) ang += Deg360;
		if (ang > Deg90) begin
			ang -= Deg180;
			neg = 1'b1;
		end else if (ang < -Deg90) begin
			ang += Deg180;
			neg = 1'b1;
		end
		z = ang;
		for (int i = 0; i < Steps && i < MaxSteps; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_deg(i[4:0]));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_deg(i[4:0]));
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic void sphere_xyz(input longint lat, input longint lon, input longint r,
			output longint px, output longint py, output longint pz);
		longint clat, slat, clon, slon, rc;
		cordic_sincos(lat, clat, slat);
		cordic_sincos(lon, clon, slon);
		rc = mul_q30(r, clat);
		px = mul_q30(rc, clon);
		py = mul_q30(rc, slon);
		pz = mul_q30(r, slat);
	endfunction

	// Tracks the reference point, the running minimum and the expected words.
	class nearest_tracker;
		longint ref_x, ref_y, ref_z;
		bit [43:0] min_sq;
		bit [23:0] near_icao;
		bit [63:0] near_call;
		bit [15:0] near_country;
		nearest_t pending[$];

		function new();
			min_sq = DistMax;
			near_icao = '0;
			near_call = '0;
			near_country = '0;
			set_reference(0, 0);
		endfunction

		function void set_reference(input int lat, input int lon);
			sphere_xyz(lat, lon, longint'(RefRadius), ref_x, ref_y, ref_z);
		endfunction

		function void note_report(input report_t rp);
			longint r, px, py, pz, d;
			longint diff[3];
			nearest_t w;
			r = ((64'sd6371000 + rp.alt) * 256 + 500) / 1000;
			sphere_xyz(rp.lat, rp.lon, r, px, py, pz);
			diff[0] = px - ref_x;
			diff[1] = py - ref_y;
			diff[2] = pz - ref_z;
			d = 0;
			foreach (diff[k]) d += diff[k] * diff[k];
			if (d > Mask44 || d < 0) d = Mask44;
			if (rp.first) begin
				min_sq = DistMax;
				near_icao = '0;
				near_call = '0;
				near_country = '0;
			end
			w.upd = 1'b0;
			if (d < min_sq) begin
				min_sq = d[43:0];
				near_icao = rp.icao;
				near_call = rp.call;
				near_country = rp.country;
				w.upd = 1'b1;
			end
			w.item_sq = d[43:0];
			w.best = min_sq;
			w.icao = near_icao;
			w.call = near_call;
			w.country = near_country;
			pending.push_back(w);
		endfunction

		task check_word(input logic [199:0] data);
			nearest_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result word", data[43:0], 0);
				return;
			end
			w = pending.pop_front();
			if (data[43:0] !== w.item_sq)
				report_mismatch("item_distance_sq", data[43:0], w.item_sq);
			if (data[44] !== w.upd) report_mismatch("updated", data[44], w.upd);
			if (data[88:45] !== w.best) report_mismatch("best_distance_sq", data[88:45], w.best);
			if (data[112:89] !== w.icao) report_mismatch("best_icao", data[112:89], w.icao);
			if (data[176:113] !== w.call)
				report_mismatch("best_call_sign", data[176:113], w.call);
			if (data[192:177] !== w.country)
				report_mismatch("closest country tag", data[192:177], w.country);
			if (data[199:193] !== '0) report_mismatch("pad", data[199:193], 0);
		endtask
	endclass

	nearest_tracker tracker = new();

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) @(negedge clk);
	endtask

	// Drops the input valid and idles; a zero gap keeps the stream going.
	task automatic sender_gap(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			idle_cycles(n);
		end
	endtask

	// Offers one report and waits until it is taken; valid stays up for the
	// caller to drop or to reuse with the next report.
	task automatic send_report(input report_t rp);
		s_axis_tdata <= {7'b0, 16'(rp.alt), 25'(rp.lon), 24'(rp.lat), rp.country, rp.call,
			rp.icao};
		s_axis_tuser <= rp.first;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_report(rp);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [0:0] idx, input int value);
		cfg_index <= idx;
		cfg_data <= 25'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Waits for all results, lets the block settle, then rewrites the reference.
	task automatic set_reference(input int lat, input int lon);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(negedge clk);
		idle_cycles(2 * Steps + 20);
		write_register(RegLat, lat);
		write_register(RegLon, lon);
		cfg_valid <= 1'b0;
		tracker.set_reference(lat, lon);
	endtask

	function automatic report_t random_report(input bit wild);
		report_t rp;
		rp.first = ($urandom_range(0, 15) == 0);
		rp.icao = 24'($urandom());
		rp.call = {$urandom(), $urandom()};
		rp.country = 16'($urandom());
		if (wild) begin
			// Any bit pattern of the angle fields, which exercises the wrap logic.
			rp.lat = $signed(24'($urandom()));
			rp.lon = $signed(25'($urandom()));
			rp.alt = $signed(16'($urandom()));
		end else begin
			rp.lat = int'($urandom_range(0, 2 * 5898240)) - 5898240;
			rp.lon = int'($urandom_range(0, 2 * 11796480)) - 11796480;
			rp.alt = int'($urandom_range(0, 21000)) - 1000;
		end
		return rp;
	endfunction

	function automatic report_t make_report(input bit first, input int lat, input int lon,
			input int alt);
		report_t rp;
		rp = random_report(1'b0);
		rp.first = first;
		rp.lat = lat;
		rp.lon = lon;
		rp.alt = alt;
		return rp;
	endfunction

	// The receiver takes words at the rising edge and idles at random, with a long
	// hold-off while hold_rx is set.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_rx = 1'b0;
			end
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g != 0) begin
				m_axis_tready <= 1'b0;
				idle_cycles(g);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) tracker.check_word(m_axis_tdata);

	initial begin
		report_t rp;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_cycles(2 * Steps + 20);

		// Directed: extremes of every field, ties and a fresh scan.
		send_report(make_report(1'b0, 0, 0, 0));
		send_report(make_report(1'b0, 0, 0, 0));
		send_report(make_report(1'b0, 5898240, 11796479, 20000));
		send_report(make_report(1'b0, -5898240, -11796480, -1000));
		send_report(make_report(1'b1, 5898240, 0, -1000));
		send_report(make_report(1'b0, -5898240, 0, 20000));
		send_report(make_report(1'b0, 0, 11796480, 0));
		send_report(make_report(1'b0, 0, -11796480, 0));
		send_report(make_report(1'b1, 8388607, 16777215, 32767));
		send_report(make_report(1'b0, -8388608, -16777216, -32768));
		send_report(make_report(1'b0, 0, 5898241, 0));
		send_report(make_report(1'b0, 0, -5898241, 0));
		rp = make_report(1'b1, 0, 0, 0);
		rp.icao = '1;
		rp.call = '1;
		rp.country = '1;
		send_report(rp);
		rp = make_report(1'b0, 0, 0, 0);
		rp.icao = 0;
		rp.call = 0;
		rp.country = 0;
		send_report(rp);

		// Reference at the extremes; antipodal reports give the largest distances.
		set_reference(5898240, 11796479);
		send_report(make_report(1'b1, -5898240, 0, 20000));
		send_report(make_report(1'b0, 5898240, 11796479, 0));
		set_reference(-5898240, -11796480);
		send_report(make_report(1'b1, 5898240, 0, 20000));
		send_report(make_report(1'b0, -5898240, -11796480, 0));
		set_reference(-8388608, 16777215);
		send_report(make_report(1'b1, 0, 0, 0));

		// Random phases, each under its own reference.
		for (int ph = 0; ph < 5; ph++) begin
			set_reference(int'($urandom_range(0, 2 * 5898240)) - 5898240,
				int'($urandom_range(0, 2 * 11796480)) - 11796480);
			for (int n = 0; n < 85; n++) begin
				if (ph == 2 && n == 10) hold_rx = 1'b1;
				if (!(ph == 2 && n < 30)) sender_gap(gap_len());
				send_report(random_report($urandom_range(0, 9) == 0));
			end
		end

		s_axis_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(negedge clk);
		idle_cycles(2 * Steps + 20);
		if (errors == 0)
			$display("nearest_position_on_sphere_tracker verification clean");
		else
			$display("nearest_position_on_sphere_tracker verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("nearest_position_on_sphere_tracker verification failed");
		$finish;
	end
endmodule

[files.f]
hdl/npst_pkg.sv
hdl/npst_ctrl.sv
hdl/npst_datapath.sv
hdl/nearest_position_on_sphere_tracker.sv
tb/nearest_position_on_sphere_tracker_tb.sv
